// ----- rtl/core/bcfs_pkg.sv -----
// Shared constants for the bilinear cover-fit scaler.
package bcfs_pkg;

    // Frame store geometry
    localparam int MAX_SRC_WIDTH  = 1024;
    localparam int MAX_SRC_HEIGHT = 1024;

    // Index widths (column, row) and widths that hold a saturated size
    localparam int X_W  = $clog2(MAX_SRC_WIDTH);
    localparam int Y_W  = $clog2(MAX_SRC_HEIGHT);
    localparam int XS_W = $clog2(MAX_SRC_WIDTH + 1);
    localparam int YS_W = $clog2(MAX_SRC_HEIGHT + 1);

    // Four banks split by column and row parity; each bank holds half of each axis
    localparam int BANK_COL_W = X_W - 1;
    localparam int BANK_ROW_W = Y_W - 1;
    localparam int BANK_AW    = BANK_COL_W + BANK_ROW_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int BANK_COUNT = 4;

    // Field widths
    localparam int COORD_W = 13;
    localparam int SIZE_W  = 11;
    localparam int Q16_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int ARGB_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed-point constants
    localparam logic [WGT_W-1:0]  WEIGHT_ONE = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_EDGE  = 16'hffff;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X_Q16    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y_Q16    = 3'd4;

    // Commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

// ----- rtl/core/bilinear_cover_fit_scaler_unit.sv -----
// Top level of the bilinear cover-fit scaler: frame store plus sampling pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | command, coord_x, coord_y, red/green/blue_in
//  output   | out_valid/out_ready  | argb_pixel
//  config   | cfg_write            | cfg_index, cfg_data
//
// One transaction per cycle is accepted while the output is not held; a sample's pixel
// passes one register stage after another (capture, position multiply, add and edge
// clamp, banked store read with weight multiply, blend). Writes land in the store in
// the banked store read stage and produce nothing on the output.
// The four neighbors sit in four parity banks, one read port each, so a sample
// reads all four at once. A held output stalls all stages together.
// Reset clears valid bits and presets config; payload regs and store are not cleared.
module bilinear_cover_fit_scaler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [bcfs_pkg::COORD_W-1:0]      coord_x,
    input  logic [bcfs_pkg::COORD_W-1:0]      coord_y,
    input  logic [bcfs_pkg::CHAN_W-1:0]       red_in,
    input  logic [bcfs_pkg::CHAN_W-1:0]       green_in,
    input  logic [bcfs_pkg::CHAN_W-1:0]       blue_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcfs_pkg::ARGB_W-1:0]       argb_pixel,
    input  logic                              cfg_write,
    input  logic [bcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcfs_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [Q16_W-1:0]  step_reg;
    logic [Q16_W-1:0]  base_x_reg;
    logic [Q16_W-1:0]  base_y_reg;

    // Pipeline control
    logic pipe_en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s4_valid_next;

    // Stage 1: captured transaction
    logic                s1_cmd_reg;
    logic [COORD_W-1:0]  s1_x_reg, s1_y_reg;
    logic [PIX_W-1:0]    s1_pix_reg;

    // Stage 2: position products
    logic                s2_cmd_reg;
    logic [COORD_W-1:0]  s2_x_reg, s2_y_reg;
    logic [PIX_W-1:0]    s2_pix_reg;
    logic [Q16_W-1:0]    s2_mul_x_reg, s2_mul_y_reg;
    logic [Q16_W-1:0]    s2_mul_x_next, s2_mul_y_next;

    // Stage 3: located neighbors and fractions
    logic                s3_cmd_reg;
    logic [COORD_W-1:0]  s3_x_reg, s3_y_reg;
    logic [PIX_W-1:0]    s3_pix_reg;
    logic [X_W-1:0]      s3_ix_reg, s3_ix_next;
    logic [Y_W-1:0]      s3_iy_reg, s3_iy_next;
    logic [FRAC_W-1:0]   s3_tx_reg, s3_tx_next;
    logic [FRAC_W-1:0]   s3_ty_reg, s3_ty_next;
    logic [Q16_W-1:0]    pos_x, pos_y;
    logic [XS_W-1:0]     w_sat;
    logic [YS_W-1:0]     h_sat;

    // Stage 4: neighbor pixels and weights
    logic [PIX_W-1:0]    s4_pix_reg [BANK_COUNT];
    logic                s4_px_reg, s4_py_reg;
    logic [WGT_W-1:0]    s4_w00_reg, s4_w10_reg, s4_w01_reg, s4_w11_reg;
    logic [WGT_W-1:0]    s4_w00_next, s4_w10_next, s4_w01_next, s4_w11_next;
    logic [WGT_W-1:0]    ax, ay;
    logic [2*WGT_W-1:0]  prod00, prod10, prod01, prod11;

    // Store access
    logic [BANK_AW-1:0]  rd_addr [BANK_COUNT];
    logic [BANK_AW-1:0]  wr_addr;
    logic [BANK_COUNT-1:0] wr_en;
    logic [BANK_COL_W-1:0] col_even, col_odd;
    logic [BANK_ROW_W-1:0] row_even, row_odd;
    logic [X_W-1:0]      ix_plus;
    logic [Y_W-1:0]      iy_plus;
    logic                wr_in_range;

    // Stage 5: blended output
    logic [ARGB_W-1:0]   s5_argb_reg, s5_argb_next;
    logic [PIX_W-1:0]    p00, p10, p01, p11;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(2);
            height_reg <= SIZE_W'(2);
            step_reg   <= Q16_W'(32'h0001_0000);
            base_x_reg <= '0;
            base_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_STEP_Q16:      step_reg   <= cfg_data[Q16_W-1:0];
                REG_BASE_X_Q16:    base_x_reg <= cfg_data[Q16_W-1:0];
                REG_BASE_Y_Q16:    base_y_reg <= cfg_data[Q16_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: everything moves unless the output is held
    assign pipe_en  = !s5_valid_reg || out_ready;
    assign in_ready = pipe_en;

    // Valid bits; writes drop out after the store stage
    assign s4_valid_next = s3_valid_reg && (s3_cmd_reg == CMD_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 2 logic: coordinate times step, modulo 2^32
    assign s2_mul_x_next = {{(Q16_W-COORD_W){1'b0}}, s1_x_reg} * step_reg;
    assign s2_mul_y_next = {{(Q16_W-COORD_W){1'b0}}, s1_y_reg} * step_reg;

    // Stage 3 logic: saturate sizes, add base, clamp at the far edge
    always_comb
    begin
        if (width_reg < SIZE_W'(2))
            w_sat = XS_W'(2);
        else if (32'(width_reg) > 32'(MAX_SRC_WIDTH))
            w_sat = XS_W'(MAX_SRC_WIDTH);
        else
            w_sat = XS_W'(width_reg);

        if (height_reg < SIZE_W'(2))
            h_sat = YS_W'(2);
        else if (32'(height_reg) > 32'(MAX_SRC_HEIGHT))
            h_sat = YS_W'(MAX_SRC_HEIGHT);
        else
            h_sat = YS_W'(height_reg);

        pos_x = base_x_reg + s2_mul_x_reg;
        pos_y = base_y_reg + s2_mul_y_reg;

        if (32'(pos_x[Q16_W-1:FRAC_W]) >= 32'(w_sat - XS_W'(1)))
        begin
            s3_ix_next = X_W'(w_sat - XS_W'(2));
            s3_tx_next = FRAC_EDGE;
        end
        else
        begin
            s3_ix_next = pos_x[FRAC_W +: X_W];
            s3_tx_next = pos_x[FRAC_W-1:0];
        end

        if (32'(pos_y[Q16_W-1:FRAC_W]) >= 32'(h_sat - YS_W'(1)))
        begin
            s3_iy_next = Y_W'(h_sat - YS_W'(2));
            s3_ty_next = FRAC_EDGE;
        end
        else
        begin
            s3_iy_next = pos_y[FRAC_W +: Y_W];
            s3_ty_next = pos_y[FRAC_W-1:0];
        end
    end

    // Stage 4 logic: Q16 bilinear weights
    always_comb
    begin
        ax = WEIGHT_ONE - {1'b0, s3_tx_reg};
        ay = WEIGHT_ONE - {1'b0, s3_ty_reg};
        prod00 = ax * ay;
        prod10 = {1'b0, s3_tx_reg} * ay;
        prod01 = ax * {1'b0, s3_ty_reg};
        prod11 = {1'b0, s3_tx_reg} * {1'b0, s3_ty_reg};
        s4_w00_next = prod00[FRAC_W +: WGT_W];
        s4_w10_next = prod10[FRAC_W +: WGT_W];
        s4_w01_next = prod01[FRAC_W +: WGT_W];
        s4_w11_next = prod11[FRAC_W +: WGT_W];
    end

    // Bank addressing: the even bank of an axis takes (i+1)/2, the odd bank i/2
    always_comb
    begin
        ix_plus  = s3_ix_reg + X_W'(1);
        iy_plus  = s3_iy_reg + Y_W'(1);
        col_even = ix_plus[X_W-1:1];
        col_odd  = s3_ix_reg[X_W-1:1];
        row_even = iy_plus[Y_W-1:1];
        row_odd  = s3_iy_reg[Y_W-1:1];
        rd_addr[0] = {row_even, col_even};
        rd_addr[1] = {row_even, col_odd};
        rd_addr[2] = {row_odd,  col_even};
        rd_addr[3] = {row_odd,  col_odd};

        wr_in_range = (32'(s3_x_reg) < 32'(MAX_SRC_WIDTH))
                   && (32'(s3_y_reg) < 32'(MAX_SRC_HEIGHT));
        wr_addr = {s3_y_reg[Y_W-1:1], s3_x_reg[X_W-1:1]};
        wr_en   = '0;
        if (s3_valid_reg && (s3_cmd_reg == CMD_WRITE) && wr_in_range)
            wr_en[{s3_y_reg[0], s3_x_reg[0]}] = 1'b1;
    end

    // Four parity banks, one write and one registered read each
    for (genvar b = 0; b < BANK_COUNT; b++)
    begin : g_bank
        logic [PIX_W-1:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                if (wr_en[b])
                    bank_mem[wr_addr] <= s3_pix_reg;
                s4_pix_reg[b] <= bank_mem[rd_addr[b]];
            end
        end
    end

    // Stage 5 logic: route banks to neighbors, then blend each channel
    always_comb
    begin
        logic [CHAN_W+WGT_W+1:0] acc;
        p00 = s4_py_reg ? (s4_px_reg ? s4_pix_reg[3] : s4_pix_reg[2])
                        : (s4_px_reg ? s4_pix_reg[1] : s4_pix_reg[0]);
        p10 = s4_py_reg ? (s4_px_reg ? s4_pix_reg[2] : s4_pix_reg[3])
                        : (s4_px_reg ? s4_pix_reg[0] : s4_pix_reg[1]);
        p01 = s4_py_reg ? (s4_px_reg ? s4_pix_reg[1] : s4_pix_reg[0])
                        : (s4_px_reg ? s4_pix_reg[3] : s4_pix_reg[2]);
        p11 = s4_py_reg ? (s4_px_reg ? s4_pix_reg[0] : s4_pix_reg[1])
                        : (s4_px_reg ? s4_pix_reg[2] : s4_pix_reg[3]);
        s5_argb_next = {ALPHA_OPAQUE, {PIX_W{1'b0}}};
        for (int c = 0; c < 3; c++)
        begin
            acc = (CHAN_W+WGT_W+2)'(p00[c*CHAN_W +: CHAN_W] * s4_w00_reg)
                + (CHAN_W+WGT_W+2)'(p10[c*CHAN_W +: CHAN_W] * s4_w10_reg)
                + (CHAN_W+WGT_W+2)'(p01[c*CHAN_W +: CHAN_W] * s4_w01_reg)
                + (CHAN_W+WGT_W+2)'(p11[c*CHAN_W +: CHAN_W] * s4_w11_reg);
            s5_argb_next[c*CHAN_W +: CHAN_W] = acc[FRAC_W +: CHAN_W];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_cmd_reg   <= command;
            s1_x_reg     <= coord_x;
            s1_y_reg     <= coord_y;
            s1_pix_reg   <= {red_in, green_in, blue_in};

            s2_cmd_reg   <= s1_cmd_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_mul_x_reg <= s2_mul_x_next;
            s2_mul_y_reg <= s2_mul_y_next;

            s3_cmd_reg   <= s2_cmd_reg;
            s3_x_reg     <= s2_x_reg;
            s3_y_reg     <= s2_y_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_ix_reg    <= s3_ix_next;
            s3_iy_reg    <= s3_iy_next;
            s3_tx_reg    <= s3_tx_next;
            s3_ty_reg    <= s3_ty_next;

            s4_px_reg    <= s3_ix_reg[0];
            s4_py_reg    <= s3_iy_reg[0];
            s4_w00_reg   <= s4_w00_next;
            s4_w10_reg   <= s4_w10_next;
            s4_w01_reg   <= s4_w01_next;
            s4_w11_reg   <= s4_w11_next;

            s5_argb_reg  <= s5_argb_next;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign argb_pixel = s5_argb_reg;

`ifndef ASSERT_OFF
    // A held output freezes the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while output is held");

    // A write leaves no item behind the store stage
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_en && s3_valid_reg && (s3_cmd_reg == CMD_WRITE)) |=> !s4_valid_reg)
        else $error("write transaction produced a result");

    // Located column and row stay inside the image
    a_index_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_cmd_reg == CMD_SAMPLE)) |->
        ((32'(s3_ix_reg) <= 32'(w_sat) - 32'd2) && (32'(s3_iy_reg) <= 32'(h_sat) - 32'd2)))
        else $error("neighbor index past the image edge");

    // Weights never sum past one, so the blend cannot overflow a channel
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (({2'b00, s4_w00_reg} + {2'b00, s4_w10_reg}
                         + {2'b00, s4_w01_reg} + {2'b00, s4_w11_reg}) <= 19'h10000))
        else $error("bilinear weights exceed unity");

    // A new result only follows a sample in the stage before
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s5_valid_reg) |-> $past(s4_valid_reg))
        else $error("result without a preceding sample");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the bilinear cover-fit scaler: store writes, samples, config phases.
`timescale 1ns / 100ps

module tb_top;
    import bcfs_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 60;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 70;
    localparam int DIR_ROWS     = 21;

    // Receiver stall patterns
    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_MASK, READY_SPARSE} stall_mode_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [Q16_W-1:0]  step;
        logic [Q16_W-1:0]  base_x;
        logic [Q16_W-1:0]  base_y;
    } scaler_cfg_t;

    // Top-left store address of the four neighbors plus the Q16 fractions
    typedef struct packed {
        logic [31:0]       origin;
        logic [FRAC_W-1:0] tx;
        logic [FRAC_W-1:0] ty;
    } src_pos_t;

    typedef struct packed {
        logic              cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              known;
        logic [ARGB_W-1:0] pixel;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
    logic [CHAN_W-1:0]     red_in;
    logic [CHAN_W-1:0]     green_in;
    logic [CHAN_W-1:0]     blue_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [ARGB_W-1:0]     argb_pixel;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the frame store (only written entries exist) and the register copy
    logic [PIX_W-1:0]  frame_mirror [int unsigned];
    scaler_cfg_t       cur_cfg;
    logic [ARGB_W-1:0] expected_pixels [$];
    int                mismatch_count;
    int                accepted_items;
    int                burst_left;
    int                idle_cycles;

    // Directed rows run under the reset register values (2x2 image, unit step, no offset)
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_WRITE,  13'd0,    13'd0,    8'hff, 8'h00, 8'h80, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd1,    13'd0,    8'h00, 8'hff, 8'h00, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd0,    13'd1,    8'h00, 8'h00, 8'hff, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd1,    13'd1,    8'hff, 8'hff, 8'hff, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd0,    13'd0,    8'h00, 8'h00, 8'h00, 1'b1, 32'hffff0080},
        '{CMD_SAMPLE, 13'd1,    13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd8191, 13'd8191, 8'hff, 8'hff, 8'hff, 1'b0, 32'h0},
        // writes past the store edge must not alias onto stored pixels
        '{CMD_WRITE,  13'd1025, 13'd0,    8'h12, 8'h34, 8'h56, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd0,    13'd1024, 8'h12, 8'h34, 8'h56, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd8191, 13'd8191, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd0,    13'd0,    8'h00, 8'h00, 8'h00, 1'b1, 32'hffff0080},
        '{CMD_SAMPLE, 13'd1,    13'd1,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        '{CMD_WRITE,  13'd0,    13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd0,    13'd0,    8'h00, 8'h00, 8'h00, 1'b1, 32'hff000000},
        '{CMD_WRITE,  13'd0,    13'd0,    8'hff, 8'hff, 8'hff, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd0,    13'd0,    8'h00, 8'h00, 8'h00, 1'b1, 32'hffffffff},
        '{CMD_WRITE,  13'd1023, 13'd1023, 8'hab, 8'hcd, 8'hef, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd0,    13'd1,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        // write immediately followed by a sample of the same pixel
        '{CMD_WRITE,  13'd1,    13'd0,    8'h5a, 8'ha5, 8'h3c, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd1,    13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        '{CMD_SAMPLE, 13'd4096, 13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 32'h0}
    };

    bilinear_cover_fit_scaler_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .argb_pixel (argb_pixel),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Size saturation as the block applies it
    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned max);
        if (v < 2)
            return 2;
        if (v > max)
            return max;
        return v;
    endfunction

    // Store address of corner k: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
    function automatic int unsigned corner_addr(int unsigned origin, int k);
        return origin + (k % 2) + (k / 2) * MAX_SRC_WIDTH;
    endfunction

    // Output coordinate to source position, with the edge clamp
    function automatic src_pos_t map_position(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
        int unsigned wsz;
        int unsigned hsz;
        logic [31:0] sx;
        logic [31:0] sy;
        int unsigned ix;
        int unsigned iy;
        src_pos_t    p;
        wsz = clamp_size(cur_cfg.width, MAX_SRC_WIDTH);
        hsz = clamp_size(cur_cfg.height, MAX_SRC_HEIGHT);
        sx = cur_cfg.base_x + ox * cur_cfg.step;
        sy = cur_cfg.base_y + oy * cur_cfg.step;
        ix = sx >> 16;
        iy = sy >> 16;
        p.tx = sx[FRAC_W-1:0];
        p.ty = sy[FRAC_W-1:0];
        if (ix >= wsz - 1)
        begin
            ix = wsz - 2;
            p.tx = FRAC_EDGE;
        end
        if (iy >= hsz - 1)
        begin
            iy = hsz - 2;
            p.ty = FRAC_EDGE;
        end
        p.origin = iy * MAX_SRC_WIDTH + ix;
        return p;
    endfunction

    // Q16 bilinear blend of the four neighbors into an opaque ARGB pixel
    function automatic logic [ARGB_W-1:0] blend_pixel(logic [COORD_W-1:0] ox,
                                                      logic [COORD_W-1:0] oy);
        src_pos_t          p;
        logic [PIX_W-1:0]  px [4];
        logic [63:0]       ax;
        logic [63:0]       ay;
        logic [63:0]       tx;
        logic [63:0]       ty;
        logic [31:0]       wt [4];
        logic [31:0]       acc;
        logic [ARGB_W-1:0] res;
        int                k;
        int                c;
        p = map_position(ox, oy);
        for (k = 0; k < 4; k++)
            px[k] = frame_mirror[corner_addr(p.origin, k)];
        tx = p.tx;
        ty = p.ty;
        ax = WEIGHT_ONE - tx;
        ay = WEIGHT_ONE - ty;
        wt[0] = 32'((ax * ay) >> 16);
        wt[1] = 32'((tx * ay) >> 16);
        wt[2] = 32'((ax * ty) >> 16);
        wt[3] = 32'((tx * ty) >> 16);
        res = {ALPHA_OPAQUE, 24'h0};
        for (c = 0; c < 3; c++)
        begin
            acc = px[0][c*CHAN_W +: CHAN_W] * wt[0] + px[1][c*CHAN_W +: CHAN_W] * wt[1]
                + px[2][c*CHAN_W +: CHAN_W] * wt[2] + px[3][c*CHAN_W +: CHAN_W] * wt[3];
            res[c*CHAN_W +: CHAN_W] = acc[23:16];
        end
        return res;
    endfunction

    // Output coordinate that lands near a random point of the image, sometimes anywhere
    function automatic logic [COORD_W-1:0] aim_coord(int unsigned size, logic [31:0] base);
        logic [31:0] tgt;
        logic [31:0] steps_off;
        if (cur_cfg.step == 0 || $urandom_range(0, 4) == 0)
            return COORD_W'($urandom_range(0, COORD_MAX));
        tgt = $urandom_range(0, (size + 1) * 65536 - 1);
        steps_off = (tgt - base) / cur_cfg.step;
        if (steps_off > COORD_MAX)
            return COORD_W'($urandom_range(0, COORD_MAX));
        return steps_off[COORD_W-1:0];
    endfunction

    // Register settings: edge cases first, then random ones biased to small images
    function automatic scaler_cfg_t pick_config(int ph);
        scaler_cfg_t c;
        int unsigned wsz;
        case (ph)
            0: c = '{11'd0, 11'd1, 32'h0, 32'h0, 32'h0};
            1: c = '{11'd2047, 11'd2047, 32'hffffffff, 32'hffffffff, 32'hffffffff};
            2: c = '{11'd1024, 11'd1024, 32'h00010000, 32'h03fc0000, 32'h03fd8000};
            3: c = '{11'd1025, 11'd3, 32'h00000001, 32'h00008000, 32'h0};
            4: c = '{11'd16, 11'd16, 32'h00008000, 32'hfffe0000, 32'hffff8000};
            default:
            begin
                c.width  = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(2, 24))
                                                      : SIZE_W'($urandom_range(0, 2047));
                c.height = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(2, 24))
                                                      : SIZE_W'($urandom_range(0, 2047));
                case ($urandom_range(0, 3))
                    0: c.step = $urandom();
                    1: c.step = $urandom_range(0, 32'h1ffff);
                    default: c.step = $urandom_range(32'h2000, 32'h30000);
                endcase
                wsz = clamp_size(c.width, MAX_SRC_WIDTH);
                c.base_x = ($urandom_range(0, 4) < 3) ? $urandom_range(0, wsz << 16) : $urandom();
                wsz = clamp_size(c.height, MAX_SRC_HEIGHT);
                c.base_y = ($urandom_range(0, 4) < 3) ? $urandom_range(0, wsz << 16) : $urandom();
            end
        endcase
        return c;
    endfunction

    // Offer one input transaction in bursts with random gaps; mirror it once accepted
    task automatic push_item(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                             logic known, logic [ARGB_W-1:0] pixel);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        coord_x  <= x;
        coord_y  <= y;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (cmd == CMD_SAMPLE)
        begin
            expected_pixels.push_back(known ? pixel : blend_pixel(x, y));
            accepted_items++;
        end
        else if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT)
        begin
            frame_mirror[y * MAX_SRC_WIDTH + x] = {r, g, b};
            accepted_items++;
        end
    endtask

    // Stop offering, let every expected pixel arrive, then let the pipeline empty
    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Program all five registers; size writes carry junk above bit 10
    task automatic load_config(scaler_cfg_t c);
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        wdata = $urandom();
        hdata = $urandom();
        wdata[SIZE_W-1:0] = c.width;
        hdata[SIZE_W-1:0] = c.height;
        reg_write(REG_SOURCE_WIDTH, wdata);
        reg_write(REG_SOURCE_HEIGHT, hdata);
        reg_write(REG_STEP_Q16, c.step);
        reg_write(REG_BASE_X_Q16, c.base_x);
        reg_write(REG_BASE_Y_Q16, c.base_y);
        cfg_write <= 1'b0;
        cur_cfg = c;
    endtask

    // Mostly samples preceded by writes of any missing neighbor; some loose and stray writes
    task automatic run_phase(int n_items);
        int               start;
        int               k;
        int unsigned      a;
        int unsigned      wsz;
        int unsigned      hsz;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        src_pos_t         p;
        start = accepted_items;
        wsz = clamp_size(cur_cfg.width, MAX_SRC_WIDTH);
        hsz = clamp_size(cur_cfg.height, MAX_SRC_HEIGHT);
        while (accepted_items - start < n_items)
        begin
            case ($urandom_range(0, 9))
                8:
                    push_item(CMD_WRITE, COORD_W'($urandom_range(0, wsz - 1)),
                              COORD_W'($urandom_range(0, hsz - 1)),
                              $urandom(), $urandom(), $urandom(), 1'b0, '0);
                9:
                    push_item(CMD_WRITE, COORD_W'($urandom_range(0, COORD_MAX)),
                              COORD_W'($urandom_range(0, COORD_MAX)),
                              $urandom(), $urandom(), $urandom(), 1'b0, '0);
                default:
                begin
                    ox = aim_coord(wsz, cur_cfg.base_x);
                    oy = aim_coord(hsz, cur_cfg.base_y);
                    p = map_position(ox, oy);
                    for (k = 0; k < 4; k++)
                    begin
                        a = corner_addr(p.origin, k);
                        if (!frame_mirror.exists(a) || $urandom_range(0, 7) == 0)
                            push_item(CMD_WRITE, COORD_W'(a % MAX_SRC_WIDTH),
                                      COORD_W'(a / MAX_SRC_WIDTH),
                                      $urandom(), $urandom(), $urandom(), 1'b0, '0);
                    end
                    push_item(CMD_SAMPLE, ox, oy, $urandom(), $urandom(), $urandom(), 1'b0, '0);
                end
            endcase
        end
    endtask

    // Output checker: each output transaction against the oldest expected pixel
    always @(posedge clk)
    begin : pixel_check
        logic [ARGB_W-1:0] want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel: expected none actual %h", $time, argb_pixel);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (argb_pixel !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: argb_pixel mismatch: expected %h actual %h",
                                 $time, want, argb_pixel);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) || cfg_write || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver: ready follows a pattern picked per stretch
    initial
    begin : ready_driver
        stall_mode_t mode;
        int          span;
        int          i;
        logic [7:0]  mask;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            mask = $urandom();
            mask[0] = 1'b1;
            for (i = 0; i < span; i++)
            begin
                @(posedge clk);
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    READY_MASK:   out_ready <= mask[i % 8];
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, register phases, drain and verdict
    initial
    begin : main_seq
        int ph;
        in_valid       <= 1'b0;
        command        <= CMD_WRITE;
        coord_x        <= '0;
        coord_y        <= '0;
        red_in         <= '0;
        green_in       <= '0;
        blue_in        <= '0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_SOURCE_WIDTH;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        mismatch_count = 0;
        accepted_items = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        cur_cfg        = '{11'd2, 11'd2, 32'h00010000, 32'h0, 32'h0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_item(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                      directed_rows[i].known, directed_rows[i].pixel);

        for (ph = 0; ph < PHASES; ph++)
        begin
            quiesce();
            load_config(pick_config(ph));
            run_phase(PHASE_ITEMS);
        end

        quiesce();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
